FILE: rtl/core/fan_duty_hysteresis_kickstart_macros.svh
// Assertion macros for the fan duty controller.
`ifndef FAN_DUTY_HYSTERESIS_KICKSTART_MACROS_SVH
`define FAN_DUTY_HYSTERESIS_KICKSTART_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FDHK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("fdhk assertion failed");

// Next-cycle implication, disabled during reset.
`define FDHK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("fdhk assertion failed");

`endif

FILE: rtl/core/fdhk_pkg.sv
// Package: types, constants and helpers for the fan duty controller.
package fdhk_pkg;

	localparam int TEMP_W = 12;
	localparam int DUTY_W = 7;
	localparam int CODE_W = 16;
	localparam int TIME_W = 32;
	localparam int KICK_W = 16;
	localparam int CMP_OUT_W = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int DUTY_SCALE_DEFAULT = 10;

	localparam logic [CODE_W-1:0] STOP_CODE_EMERGENCY = 16'd401;
	localparam logic [DUTY_W-1:0] FULL_DUTY = 7'd100;
	localparam logic [DUTY_W:0] NO_DUTY_APPLIED = 8'd255;
	localparam int COMPARE_MAX = 1023;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LATCH_SET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LATCH_CLEAR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_MID = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_DUTY = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MID_DUTY = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_KICK_DUR = 3'd7;

	typedef struct packed {
		logic signed [TEMP_W-1:0] latch_set_level;
		logic signed [TEMP_W-1:0] latch_clear_level;
		logic signed [TEMP_W-1:0] band_low_level;
		logic signed [TEMP_W-1:0] band_mid_level;
		logic signed [TEMP_W-1:0] band_high_level;
		logic [DUTY_W-1:0] low_duty;
		logic [DUTY_W-1:0] mid_duty;
		logic [KICK_W-1:0] kick_duration_ms;
	} fdhk_cfg_t;

	typedef struct packed {
		logic hot_latch;
		logic [DUTY_W-1:0] last_target_duty;
		logic [DUTY_W:0] last_applied_duty;
		logic [TIME_W-1:0] kick_deadline;
	} fdhk_state_t;

	typedef struct packed {
		logic [CMP_OUT_W-1:0] compare_value;
		logic compare_write;
		logic [DUTY_W-1:0] applied_duty;
		logic hot_latched;
	} fdhk_result_t;

	function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W-1:0] d);
		return (d > FULL_DUTY) ? FULL_DUTY : d;
	endfunction

endpackage

FILE: rtl/core/fdhk_cfg.sv
// Configuration register file of the fan duty controller.
module fdhk_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [fdhk_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [fdhk_pkg::CFG_DATA_W-1:0]    wr_data,
	output fdhk_pkg::fdhk_cfg_t                cfg
);
	import fdhk_pkg::*;

	fdhk_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.latch_set_level <= 12'sd310;
			cfg_q.latch_clear_level <= 12'sd280;
			cfg_q.band_low_level <= 12'sd260;
			cfg_q.band_mid_level <= 12'sd280;
			cfg_q.band_high_level <= 12'sd300;
			cfg_q.low_duty <= 7'd30;
			cfg_q.mid_duty <= 7'd60;
			cfg_q.kick_duration_ms <= 16'd400;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LATCH_SET: cfg_q.latch_set_level <= wr_data[TEMP_W-1:0];
				REG_LATCH_CLEAR: cfg_q.latch_clear_level <= wr_data[TEMP_W-1:0];
				REG_BAND_LOW: cfg_q.band_low_level <= wr_data[TEMP_W-1:0];
				REG_BAND_MID: cfg_q.band_mid_level <= wr_data[TEMP_W-1:0];
				REG_BAND_HIGH: cfg_q.band_high_level <= wr_data[TEMP_W-1:0];
				REG_LOW_DUTY: cfg_q.low_duty <= wr_data[DUTY_W-1:0];
				REG_MID_DUTY: cfg_q.mid_duty <= wr_data[DUTY_W-1:0];
				REG_KICK_DUR: cfg_q.kick_duration_ms <= wr_data[KICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/fdhk_step.sv
// Per-tick update logic: latch, band table, kickstart, compare scaling and emergency stop.
module fdhk_step #(
	parameter int DUTY_SCALE = fdhk_pkg::DUTY_SCALE_DEFAULT
) (
	input  fdhk_pkg::fdhk_cfg_t                cfg,
	input  fdhk_pkg::fdhk_state_t              state,
	input  logic signed [fdhk_pkg::TEMP_W-1:0] temp,
	input  logic [fdhk_pkg::CODE_W-1:0]        code,
	input  logic [fdhk_pkg::TIME_W-1:0]        now,
	output fdhk_pkg::fdhk_state_t              state_next,
	output fdhk_pkg::fdhk_result_t             result
);
	import fdhk_pkg::*;

	localparam int PROD_W = $clog2(100 * DUTY_SCALE + 1);
	localparam int CW = (PROD_W > CMP_OUT_W) ? PROD_W : CMP_OUT_W;

	logic               hot;
	logic [DUTY_W-1:0]  target;
	logic [DUTY_W-1:0]  apply;
	logic [TIME_W-1:0]  deadline;
	logic [TIME_W-1:0]  deadline_out;
	logic [CW-1:0]      cmp_full;
	logic [CMP_OUT_W-1:0] cmp_sat;

	always_comb begin
		priority if (temp >= cfg.latch_set_level) hot = 1'b1;
		else if (temp <= cfg.latch_clear_level) hot = 1'b0;
		else hot = state.hot_latch;

		priority if (hot) target = FULL_DUTY;
		else if (temp < cfg.band_low_level) target = '0;
		else if (temp < cfg.band_mid_level) target = sat_duty(cfg.low_duty);
		else if (temp < cfg.band_high_level) target = sat_duty(cfg.mid_duty);
		else target = FULL_DUTY;

		// kick starts only when leaving a zero target with no kick pending
		if (state.last_target_duty == '0 && state.kick_deadline == '0)
			deadline = now + TIME_W'(cfg.kick_duration_ms);
		else
			deadline = state.kick_deadline;

		if (target == '0) begin
			deadline_out = '0;
			apply = '0;
		end else if (deadline != '0 && now < deadline) begin
			deadline_out = deadline;
			apply = FULL_DUTY;
		end else begin
			deadline_out = '0;
			apply = target;
		end
	end

	assign cmp_full = CW'(apply) * CW'(DUTY_SCALE);
	assign cmp_sat = (cmp_full > CW'(COMPARE_MAX)) ? CMP_OUT_W'(COMPARE_MAX)
		: cmp_full[CMP_OUT_W-1:0];

	always_comb begin
		if (code == STOP_CODE_EMERGENCY) begin
			state_next.hot_latch = state.hot_latch;
			state_next.last_target_duty = '0;
			state_next.last_applied_duty = '0;
			state_next.kick_deadline = '0;
			result.compare_value = '0;
			result.compare_write = 1'b1;
			result.applied_duty = '0;
			result.hot_latched = state.hot_latch;
		end else begin
			state_next.hot_latch = hot;
			state_next.last_target_duty = target;
			state_next.last_applied_duty = {1'b0, apply};
			state_next.kick_deadline = deadline_out;
			result.compare_value = cmp_sat;
			result.compare_write = ({1'b0, apply} != state.last_applied_duty);
			result.applied_duty = apply;
			result.hot_latched = hot;
		end
	end

endmodule

FILE: rtl/core/fan_duty_hysteresis_kickstart.sv
// Top level of the fan duty controller: input stage, state, result register.
// Accepts one update tick per clock cycle while the result side is not
// stalled and returns exactly one result per tick, through the input and then
// result registers. The tick is held in an input register; the latch, band
// table, kickstart and compare scaling are evaluated combinationally against
// the controller state, which is updated at the same edge the result register
// loads, so the next tick sees it at once. The result register lets a new tick
// be taken while a finished result waits. Configuration registers take effect
// on the next tick and must be written only when the block is idle.
module fan_duty_hysteresis_kickstart #(
	parameter int DUTY_SCALE = fdhk_pkg::DUTY_SCALE_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [fdhk_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [fdhk_pkg::CFG_DATA_W-1:0]    wr_data,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic signed [fdhk_pkg::TEMP_W-1:0] temperature_tenths,
	input  logic [fdhk_pkg::CODE_W-1:0]        stop_code,
	input  logic [fdhk_pkg::TIME_W-1:0]        time_ms,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic [fdhk_pkg::CMP_OUT_W-1:0]     compare_value,
	output logic                               compare_write,
	output logic [fdhk_pkg::DUTY_W-1:0]        applied_duty,
	output logic                               hot_latched
);
	import fdhk_pkg::*;

`include "fan_duty_hysteresis_kickstart_macros.svh"

	fdhk_cfg_t    cfg;
	fdhk_state_t  state_q;
	fdhk_state_t  state_next;
	fdhk_result_t res_next;
	fdhk_result_t res_q;

	logic                     valid_s1;
	logic signed [TEMP_W-1:0] temp_s1;
	logic [CODE_W-1:0]        code_s1;
	logic [TIME_W-1:0]        time_s1;
	logic                     out_valid_q;
	logic                     advance;

	fdhk_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	fdhk_step #(
		.DUTY_SCALE (DUTY_SCALE)
	) u_step (
		.cfg        (cfg),
		.state      (state_q),
		.temp       (temp_s1),
		.code       (code_s1),
		.now        (time_s1),
		.state_next (state_next),
		.result     (res_next)
	);

	assign advance = valid_s1 && (!out_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			temp_s1 <= temperature_tenths;
			code_s1 <= stop_code;
			time_s1 <= time_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.hot_latch <= 1'b0;
			state_q.last_target_duty <= '0;
			state_q.last_applied_duty <= NO_DUTY_APPLIED;
			state_q.kick_deadline <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_next;
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign result_valid = out_valid_q;
	assign compare_value = res_q.compare_value;
	assign compare_write = res_q.compare_write;
	assign applied_duty = res_q.applied_duty;
	assign hot_latched = res_q.hot_latched;

	`FDHK_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, item_valid && item_ready, valid_s1)
	`FDHK_ASSERT_NOW(a_kick_needs_target, clk, arst_n, state_q.kick_deadline != '0,
		state_q.last_target_duty != '0)
	`FDHK_ASSERT_NOW(a_zero_duty_zero_cmp, clk, arst_n,
		out_valid_q && res_q.applied_duty == '0, res_q.compare_value == '0)
	`FDHK_ASSERT_NEXT(a_advance_loads_out, clk, arst_n, advance, out_valid_q)

endmodule
